[rtl/crsf_rc_channel_frame_decoder_defines.svh]
// Assertion macros for the packed RC-channel frame decoder.
// Each macro expands to a labeled concurrent assertion in simulation and to
// nothing in synthesis.
`ifndef CRSF_RC_CHANNEL_FRAME_DECODER_DEFINES_SVH
`define CRSF_RC_CHANNEL_FRAME_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
// Check that prop holds at every rising edge outside reset.
`define CRSFD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
// Check that cond never holds at a rising edge outside reset.
`define CRSFD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);
`else
`define CRSFD_ASSERT(lbl, clk, rst_n, prop, msg)
`define CRSFD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

[rtl/crsfd_pkg.sv]
`default_nettype none

package crsfd_pkg;

    // Frame layout
    localparam int CHANNEL_COUNT  = 16;
    localparam int CH_IDX_W       = $clog2(CHANNEL_COUNT);
    localparam int CHAN_W         = 11;
    localparam int BYTE_W         = 8;
    localparam int POS_W          = 5;
    localparam int ACC_W          = 18;
    localparam int BITS_W         = 5;
    localparam int STICK_CHANNELS = 4;

    localparam logic [BYTE_W-1:0] FRAME_LENGTH = 8'd24;
    localparam logic [POS_W-1:0]  POS_SYNC     = 5'd0;
    localparam logic [POS_W-1:0]  POS_LENGTH   = 5'd1;
    localparam logic [POS_W-1:0]  POS_TYPE     = 5'd2;
    localparam logic [POS_W-1:0]  POS_PAYLOAD  = 5'd3;
    localparam logic [POS_W-1:0]  POS_CRC      = 5'd25;

    localparam logic [BYTE_W-1:0] CRC_POLY = 8'hD5;

    // Scaling arithmetic
    localparam int GAIN_W   = 16;
    localparam int DIFF_W   = CHAN_W + 1;
    localparam int PROD_W   = DIFF_W + GAIN_W + 1;
    localparam int Q_SHIFT  = 8;
    localparam int VALUE_W  = 16;

    // Result command queue
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_SYNC   = 2'd1,
        ST_BAD_LENGTH = 2'd2,
        ST_BAD_CRC    = 2'd3
    } t_frame_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC        = 3'd0,
        CFG_FRAME_TYPE  = 3'd1,
        CFG_STICK_MIN   = 3'd2,
        CFG_STICK_GAIN  = 3'd3,
        CFG_AUX_MIN     = 3'd4,
        CFG_AUX_GAIN    = 3'd5
    } t_cfg_index;

    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_MUL   = 2'd1,
        BK_SCALE = 2'd2
    } t_bk_state;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_value;
        logic [BYTE_W-1:0] frame_type;
        logic [CHAN_W-1:0] stick_min;
        logic [GAIN_W-1:0] stick_gain;
        logic [CHAN_W-1:0] aux_min;
        logic [GAIN_W-1:0] aux_gain;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        sync_value: 8'd200,
        frame_type: 8'd22,
        stick_min:  11'd172,
        stick_gain: 16'd3999,
        aux_min:    11'd172,
        aux_gain:   16'd3999
    };

    // Channel store write from the parser
    typedef struct packed {
        logic                en;
        logic [CH_IDX_W-1:0] idx;
        logic [CHAN_W-1:0]   data;
    } t_store_wr;

    // Command pushed into the queue
    typedef struct packed {
        logic          en;
        t_frame_status status;
    } t_cmd_push;

    // Queue status seen by both sides
    typedef struct packed {
        logic          full;
        logic          empty;
        logic          ok_pending;
        t_frame_status head;
    } t_cmdq_status;

    // CRC-8, MSB first, one byte
    function automatic logic [BYTE_W-1:0] crc8_byte(
        input logic [BYTE_W-1:0] crc_in,
        input logic [BYTE_W-1:0] data
    );
        logic [BYTE_W-1:0] c;
        c = crc_in ^ data;
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[BYTE_W-1]) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/crsfd_cmdq.sv]
`default_nettype none

module crsfd_cmdq
    import crsfd_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_cmd_push    i_push,
    input  wire logic         i_pop,
    output t_cmdq_status      o_status
);

    t_frame_status           r_entry [CMDQ_DEPTH];
    logic [CMDQ_DEPTH-1:0]   r_vld;
    logic [CMDQ_PTR_W-1:0]   r_wr_ptr;
    logic [CMDQ_PTR_W-1:0]   r_rd_ptr;
    logic [CMDQ_DEPTH-1:0]   n_vld;
    logic [CMDQ_PTR_W-1:0]   n_wr_ptr;
    logic [CMDQ_PTR_W-1:0]   n_rd_ptr;
    logic                    ok_any;

    // Flag any queued good-frame command
    always_comb begin
        ok_any = 1'b0;
        for (int i = 0; i < CMDQ_DEPTH; i++) begin
            if (r_vld[i] && r_entry[i] == ST_OK) begin
                ok_any = 1'b1;
            end
        end
    end

    assign o_status.full       = r_vld[r_wr_ptr];
    assign o_status.empty      = !r_vld[r_rd_ptr];
    assign o_status.ok_pending = ok_any;
    assign o_status.head       = r_entry[r_rd_ptr];

    // Advance pointers and valid bits
    always_comb begin
        n_vld    = r_vld;
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (i_pop) begin
            n_vld[r_rd_ptr] = 1'b0;
            n_rd_ptr = (r_rd_ptr == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push.en) begin
            n_vld[r_wr_ptr] = 1'b1;
            n_wr_ptr = (r_wr_ptr == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_vld    <= n_vld;
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
        end
    end

    // Store the entry
    always_ff @(posedge i_clk) begin
        if (i_push.en) begin
            r_entry[r_wr_ptr] <= i_push.status;
        end
    end

endmodule

`default_nettype wire

[rtl/crsfd_front.sv]
`default_nettype none

module crsfd_front
    import crsfd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [BYTE_W-1:0] i_rx_byte,
    input  wire logic              i_frame_start,
    input  wire t_cfg              i_cfg,
    input  wire t_cmdq_status      i_q_status,
    input  wire logic              i_store_busy,
    output t_cmd_push              o_push,
    output t_store_wr              o_store_wr
);

    logic [POS_W-1:0]    r_pos;
    logic [BYTE_W-1:0]   r_crc;
    logic [ACC_W-1:0]    r_acc;
    logic [BITS_W-1:0]   r_bits;
    logic                r_discard;
    logic [CH_IDX_W-1:0] r_wr_ch;

    logic [POS_W-1:0]    n_pos;
    logic [BYTE_W-1:0]   n_crc;
    logic [ACC_W-1:0]    n_acc;
    logic [BITS_W-1:0]   n_bits;
    logic                n_discard;
    logic [CH_IDX_W-1:0] n_wr_ch;

    logic                accept;
    logic                payload_byte;
    logic [ACC_W-1:0]    acc_ins;
    logic [BITS_W-1:0]   bits_sum;
    logic [BYTE_W-1:0]   crc_next;

    // A payload byte may write the channel store
    assign payload_byte = !i_frame_start && !r_discard
                          && r_pos >= POS_PAYLOAD && r_pos < POS_CRC;
    assign o_in_stall   = i_q_status.full || (i_store_busy && payload_byte);
    assign accept       = i_in_valid && !o_in_stall;

    assign acc_ins  = r_acc | (ACC_W'(i_rx_byte) << r_bits);
    assign bits_sum = r_bits + BITS_W'(BYTE_W);
    assign crc_next = crc8_byte(r_crc, i_rx_byte);

    // Parse one byte
    always_comb begin
        logic [POS_W-1:0] pos;
        logic             discard;
        n_pos      = r_pos;
        n_crc      = r_crc;
        n_acc      = r_acc;
        n_bits     = r_bits;
        n_discard  = r_discard;
        n_wr_ch    = r_wr_ch;
        o_push     = '0;
        o_store_wr = '0;
        pos        = i_frame_start ? POS_SYNC : r_pos;
        discard    = r_discard && !i_frame_start;
        if (accept) begin
            n_pos     = pos;
            n_discard = discard;
            if (!discard) begin
                if (pos == POS_SYNC) begin
                    if (i_rx_byte != i_cfg.sync_value) begin
                        o_push.en     = 1'b1;
                        o_push.status = ST_BAD_SYNC;
                        n_discard     = 1'b1;
                    end else begin
                        n_pos = POS_LENGTH;
                    end
                end else if (pos == POS_LENGTH) begin
                    if (i_rx_byte != FRAME_LENGTH) begin
                        o_push.en     = 1'b1;
                        o_push.status = ST_BAD_LENGTH;
                        n_discard     = 1'b1;
                    end else begin
                        n_pos = POS_TYPE;
                    end
                end else if (pos == POS_TYPE) begin
                    if (i_rx_byte != i_cfg.frame_type) begin
                        o_push.en     = 1'b1;
                        o_push.status = ST_BAD_SYNC;
                        n_discard     = 1'b1;
                    end else begin
                        n_crc   = crc8_byte('0, i_rx_byte);
                        n_acc   = '0;
                        n_bits  = '0;
                        n_wr_ch = '0;
                        n_pos   = POS_PAYLOAD;
                    end
                end else if (pos < POS_CRC) begin
                    // Unpack channels LSB first
                    n_crc  = crc_next;
                    n_acc  = acc_ins;
                    n_bits = bits_sum;
                    if (bits_sum >= BITS_W'(CHAN_W)) begin
                        o_store_wr.en   = 1'b1;
                        o_store_wr.idx  = r_wr_ch;
                        o_store_wr.data = acc_ins[CHAN_W-1:0];
                        n_acc           = acc_ins >> CHAN_W;
                        n_bits          = bits_sum - BITS_W'(CHAN_W);
                        n_wr_ch         = r_wr_ch + 1'b1;
                    end
                    n_pos = pos + 1'b1;
                end else begin
                    // Check the CRC byte
                    o_push.en     = 1'b1;
                    o_push.status = (i_rx_byte == r_crc) ? ST_OK : ST_BAD_CRC;
                    n_discard     = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_crc     <= '0;
            r_acc     <= '0;
            r_bits    <= '0;
            r_discard <= 1'b1;
            r_wr_ch   <= '0;
        end else begin
            r_pos     <= n_pos;
            r_crc     <= n_crc;
            r_acc     <= n_acc;
            r_bits    <= n_bits;
            r_discard <= n_discard;
            r_wr_ch   <= n_wr_ch;
        end
    end

endmodule

`default_nettype wire

[rtl/crsfd_back.sv]
`default_nettype none

module crsfd_back
    import crsfd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cfg                  i_cfg,
    input  wire t_store_wr             i_store_wr,
    input  wire t_cmdq_status          i_q_status,
    output logic                       o_pop,
    output logic                       o_busy,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [CH_IDX_W-1:0]        o_channel_index,
    output logic signed [VALUE_W-1:0]  o_scaled_value,
    output logic [1:0]                 o_frame_status,
    output logic                       o_last_of_frame
);

    localparam logic signed [PROD_W-Q_SHIFT-1:0] Q_MAX = (PROD_W-Q_SHIFT)'(32767);
    localparam logic signed [PROD_W-Q_SHIFT-1:0] Q_MIN = -(PROD_W-Q_SHIFT)'(32768);

    t_bk_state r_state;
    t_bk_state n_state;

    logic [CHAN_W-1:0]          r_store [CHANNEL_COUNT];
    logic [CH_IDX_W-1:0]        r_ch;
    logic signed [PROD_W-1:0]   r_prod;

    logic                       r_out_valid;
    logic [CH_IDX_W-1:0]        r_out_index;
    logic signed [VALUE_W-1:0]  r_out_value;
    t_frame_status              r_out_status;
    logic                       r_out_last;

    logic                       out_free;
    logic                       load_err;
    logic                       load_ch;
    logic                       mul_en;
    logic                       is_stick;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [GAIN_W:0]     gain_s;
    logic signed [PROD_W-1:0]   n_prod;
    logic signed [PROD_W-Q_SHIFT-1:0] q;
    logic signed [VALUE_W-1:0]  sat_value;

    assign out_free = !r_out_valid || !i_out_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (!i_q_status.empty && out_free && i_q_status.head == ST_OK) begin
                    n_state = BK_MUL;
                end
            end
            BK_MUL: begin
                n_state = BK_SCALE;
            end
            BK_SCALE: begin
                if (out_free) begin
                    n_state = (r_ch == CH_IDX_W'(CHANNEL_COUNT - 1)) ? BK_IDLE : BK_MUL;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // Control outputs
    always_comb begin
        o_pop    = 1'b0;
        load_err = 1'b0;
        load_ch  = 1'b0;
        mul_en   = 1'b0;
        case (r_state)
            BK_IDLE: begin
                o_pop    = !i_q_status.empty && out_free;
                load_err = o_pop && i_q_status.head != ST_OK;
            end
            BK_MUL: begin
                mul_en = 1'b1;
            end
            BK_SCALE: begin
                load_ch = out_free;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    assign o_busy = r_state != BK_IDLE;

    // Scale one channel: subtract minimum, multiply by gain
    assign is_stick = r_ch < CH_IDX_W'(STICK_CHANNELS);
    assign diff     = $signed({1'b0, r_store[r_ch]})
                      - $signed({1'b0, is_stick ? i_cfg.stick_min : i_cfg.aux_min});
    assign gain_s   = $signed({1'b0, is_stick ? i_cfg.stick_gain : i_cfg.aux_gain});
    assign n_prod   = diff * gain_s;

    // Floor shift, then clamp to 16 bits
    assign q = r_prod[PROD_W-1:Q_SHIFT];
    always_comb begin
        if (q > Q_MAX) begin
            sat_value = VALUE_W'(Q_MAX);
        end else if (q < Q_MIN) begin
            sat_value = VALUE_W'(Q_MIN);
        end else begin
            sat_value = q[VALUE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
            r_ch        <= '0;
        end else begin
            r_state <= n_state;
            if (load_err || load_ch) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                r_ch <= '0;
            end else if (load_ch) begin
                r_ch <= r_ch + 1'b1;
            end
        end
    end

    // Hold the result word until taken
    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= n_prod;
        end
        if (load_err) begin
            r_out_index  <= '0;
            r_out_value  <= '0;
            r_out_status <= i_q_status.head;
            r_out_last   <= 1'b1;
        end else if (load_ch) begin
            r_out_index  <= r_ch;
            r_out_value  <= sat_value;
            r_out_status <= ST_OK;
            r_out_last   <= r_ch == CH_IDX_W'(CHANNEL_COUNT - 1);
        end
    end

    // Channel store, written by the parser
    always_ff @(posedge i_clk) begin
        if (i_store_wr.en) begin
            r_store[i_store_wr.idx] <= i_store_wr.data;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_channel_index = r_out_index;
    assign o_scaled_value  = r_out_value;
    assign o_frame_status  = r_out_status;
    assign o_last_of_frame = r_out_last;

endmodule

`default_nettype wire

[rtl/crsf_rc_channel_frame_decoder.sv]
// Packed RC-channel frame decoder. Takes one link byte per cycle on the input
// channel; a byte with frame start set always opens a new frame. A good frame
// (sync, length 24, type, 22 payload bytes, CRC-8 poly 0xD5) yields sixteen
// words, channels 0 to 15 in order, each a saturated signed Q8.8 value; a bad
// frame yields one error word with index 0, value 0 and last set. Each channel
// word passes through the shared multiply-and-scale unit. Parsed frames wait
// in a two-entry command queue; input stalls only when that queue is full, or
// when a payload byte arrives while a good frame is still queued or its
// channels are being scaled out of the channel store. The user must write
// configuration only while idle; the block itself does not enforce this.
`default_nettype none
`include "crsf_rc_channel_frame_decoder_defines.svh"

module crsf_rc_channel_frame_decoder
    import crsfd_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_wdata,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic [BYTE_W-1:0]       i_rx_byte,
    input  wire logic                    i_frame_start,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic [CH_IDX_W-1:0]          o_channel_index,
    output logic signed [VALUE_W-1:0]    o_scaled_value,
    output logic [1:0]                   o_frame_status,
    output logic                         o_last_of_frame
);

    t_cfg         r_cfg;
    t_cmd_push    push;
    t_store_wr    store_wr;
    t_cmdq_status q_status;
    logic         pop;
    logic         back_busy;
    logic         store_busy;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_SYNC:       r_cfg.sync_value <= i_cfg_wdata[BYTE_W-1:0];
                CFG_FRAME_TYPE: r_cfg.frame_type <= i_cfg_wdata[BYTE_W-1:0];
                CFG_STICK_MIN:  r_cfg.stick_min  <= i_cfg_wdata[CHAN_W-1:0];
                CFG_STICK_GAIN: r_cfg.stick_gain <= i_cfg_wdata[GAIN_W-1:0];
                CFG_AUX_MIN:    r_cfg.aux_min    <= i_cfg_wdata[CHAN_W-1:0];
                CFG_AUX_GAIN:   r_cfg.aux_gain   <= i_cfg_wdata[GAIN_W-1:0];
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    // Store is in use while a good frame is queued or being scaled
    assign store_busy = back_busy || q_status.ok_pending;

    crsfd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_rx_byte    (i_rx_byte),
        .i_frame_start(i_frame_start),
        .i_cfg        (r_cfg),
        .i_q_status   (q_status),
        .i_store_busy (store_busy),
        .o_push       (push),
        .o_store_wr   (store_wr)
    );

    crsfd_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_status(q_status)
    );

    crsfd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_store_wr     (store_wr),
        .i_q_status     (q_status),
        .o_pop          (pop),
        .o_busy         (back_busy),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_channel_index(o_channel_index),
        .o_scaled_value (o_scaled_value),
        .o_frame_status (o_frame_status),
        .o_last_of_frame(o_last_of_frame)
    );

    // Error words carry index 0, value 0 and close the frame
    `CRSFD_ASSERT(a_err_word, i_clk, i_rst_n,
        (o_out_valid && o_frame_status != ST_OK)
        |-> (o_last_of_frame && o_channel_index == '0 && o_scaled_value == '0),
        "error word fields wrong")
    // Good frames close exactly on the last channel
    `CRSFD_ASSERT(a_ok_last, i_clk, i_rst_n,
        (o_out_valid && o_frame_status == ST_OK)
        |-> (o_last_of_frame == (o_channel_index == CH_IDX_W'(CHANNEL_COUNT - 1))),
        "last flag misplaced")
    // Never overwrite the store while its channels are being scaled
    `CRSFD_ASSERT_NEVER(a_store_hazard, i_clk, i_rst_n, store_wr.en && store_busy,
        "store written while in use")
    // Never push into a full queue unless an entry is popped in the same cycle
    `CRSFD_ASSERT_NEVER(a_q_overflow, i_clk, i_rst_n, push.en && q_status.full && !pop,
        "command queue overflow")

endmodule

`default_nettype wire

[tb/crsf_rc_channel_frame_decoder_checker.sv]
module crsf_rc_channel_frame_decoder_checker
    import crsfd_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_wdata,
    input  wire logic                    i_in_valid,
    input  wire logic                    i_in_stall,
    input  wire logic [BYTE_W-1:0]       i_rx_byte,
    input  wire logic                    i_frame_start,
    input  wire logic                    i_out_valid,
    input  wire logic                    i_out_stall,
    input  wire logic [CH_IDX_W-1:0]     i_channel_index,
    input  wire logic signed [VALUE_W-1:0] i_scaled_value,
    input  wire logic [1:0]              i_frame_status,
    input  wire logic                    i_last_of_frame,
    output int                           o_fail_count,
    output int                           o_words_due
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [CH_IDX_W-1:0]       idx;
        logic signed [VALUE_W-1:0] value;
        t_frame_status             status;
        logic                      last;
    } t_channel_word;

    // Shadow of the decoder: settings and parse state
    t_cfg              settings;
    logic [POS_W-1:0]  byte_pos;
    logic [BYTE_W-1:0] crc_acc;
    logic [ACC_W-1:0]  bit_buf;
    logic [BITS_W-1:0] bits_in;
    logic [CHAN_W-1:0] raw_chan [CHANNEL_COUNT];
    logic              dropping;

    // Words still owed by the decoder, oldest first
    t_channel_word     due_words[$];

    function automatic logic [BYTE_W-1:0] crc_next(
        input logic [BYTE_W-1:0] crc_in,
        input logic [BYTE_W-1:0] data
    );
        logic [BYTE_W-1:0] r;
        r = crc_in ^ data;
        for (int k = 0; k < BYTE_W; k++) begin
            if (r[BYTE_W-1]) begin
                r = (r << 1) ^ CRC_POLY;
            end else begin
                r = r << 1;
            end
        end
        return r;
    endfunction

    // (raw - minimum) * gain, floor shift by 8, clamp to 16 bits signed
    function automatic logic signed [VALUE_W-1:0] percent_q88(
        input logic [CHAN_W-1:0] raw,
        input logic [CHAN_W-1:0] lo,
        input logic [GAIN_W-1:0] gain
    );
        longint prod;
        longint q;
        prod = (longint'(raw) - longint'(lo)) * longint'(gain);
        q = prod >>> Q_SHIFT;
        if (q > 32767) begin
            q = 32767;
        end else if (q < -32768) begin
            q = -32768;
        end
        return q[VALUE_W-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] %s", $time, what);
        o_fail_count++;
    endtask

    task automatic owe_error(input t_frame_status st);
        due_words.push_back('{idx: '0, value: '0, status: st, last: 1'b1});
        dropping = 1'b1;
    endtask

    // Advance the frame parser by one accepted byte
    task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic start);
        int ch;
        logic [CHAN_W-1:0] lo;
        logic [GAIN_W-1:0] gain;
        if (start) begin
            dropping = 1'b0;
            byte_pos = POS_SYNC;
        end
        if (!dropping) begin
            if (byte_pos == POS_SYNC) begin
                if (b != settings.sync_value) owe_error(ST_BAD_SYNC);
                else byte_pos = POS_LENGTH;
            end else if (byte_pos == POS_LENGTH) begin
                if (b != FRAME_LENGTH) owe_error(ST_BAD_LENGTH);
                else byte_pos = POS_TYPE;
            end else if (byte_pos == POS_TYPE) begin
                if (b != settings.frame_type) begin
                    owe_error(ST_BAD_SYNC);
                end else begin
                    crc_acc = crc_next('0, b);
                    bit_buf = '0;
                    bits_in = '0;
                    byte_pos = POS_PAYLOAD;
                end
            end else if (byte_pos < POS_CRC) begin
                // unpack 11-bit channels, LSB first
                ch = ((int'(byte_pos) - int'(POS_PAYLOAD)) * BYTE_W - int'(bits_in)) / CHAN_W;
                crc_acc = crc_next(crc_acc, b);
                bit_buf = bit_buf | (ACC_W'(b) << bits_in);
                bits_in = bits_in + BITS_W'(BYTE_W);
                while (bits_in >= CHAN_W) begin
                    raw_chan[ch % CHANNEL_COUNT] = bit_buf[CHAN_W-1:0];
                    bit_buf = bit_buf >> CHAN_W;
                    bits_in = bits_in - BITS_W'(CHAN_W);
                    ch++;
                end
                byte_pos = byte_pos + 1'b1;
            end else if (b != crc_acc) begin
                owe_error(ST_BAD_CRC);
            end else begin
                for (int i = 0; i < CHANNEL_COUNT; i++) begin
                    lo = (i < STICK_CHANNELS) ? settings.stick_min : settings.aux_min;
                    gain = (i < STICK_CHANNELS) ? settings.stick_gain : settings.aux_gain;
                    due_words.push_back('{idx: CH_IDX_W'(i),
                                          value: percent_q88(raw_chan[i], lo, gain),
                                          status: ST_OK,
                                          last: (i == CHANNEL_COUNT - 1)});
                end
                dropping = 1'b1;
            end
        end
    endtask

    // Compare one accepted word with the oldest one owed
    task automatic check_word();
        t_channel_word want;
        if (due_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word idx %0d value %0d status %0d last %0b",
                i_channel_index, i_scaled_value, i_frame_status, i_last_of_frame));
        end else begin
            want = due_words.pop_front();
            if (i_channel_index !== want.idx || i_scaled_value !== want.value ||
                i_frame_status !== want.status || i_last_of_frame !== want.last) begin
                report_mismatch($sformatf(
                    "word idx %0d value %0d status %0d last %0b, want %0d %0d %0d %0b",
                    i_channel_index, i_scaled_value, i_frame_status, i_last_of_frame,
                    want.idx, want.value, want.status, want.last));
            end
        end
    endtask

    // Track settings, predict on input words, check output words
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            settings = CFG_RESET;
            byte_pos = POS_SYNC;
            crc_acc = '0;
            bit_buf = '0;
            bits_in = '0;
            dropping = 1'b1;
            for (int i = 0; i < CHANNEL_COUNT; i++) raw_chan[i] = '0;
            due_words.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_SYNC:       settings.sync_value = i_cfg_wdata[BYTE_W-1:0];
                    CFG_FRAME_TYPE: settings.frame_type = i_cfg_wdata[BYTE_W-1:0];
                    CFG_STICK_MIN:  settings.stick_min = i_cfg_wdata[CHAN_W-1:0];
                    CFG_STICK_GAIN: settings.stick_gain = i_cfg_wdata[GAIN_W-1:0];
                    CFG_AUX_MIN:    settings.aux_min = i_cfg_wdata[CHAN_W-1:0];
                    CFG_AUX_GAIN:   settings.aux_gain = i_cfg_wdata[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) decode_byte(i_rx_byte, i_frame_start);
            if (i_out_valid && !i_out_stall) check_word();
        end
        o_words_due = due_words.size();
    end

endmodule

[tb/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import crsfd_pkg::*;

    localparam int DRAIN_CYCLES   = 48;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 56;
    localparam int REG_COUNT      = CFG_AUX_GAIN + 1;
    localparam int PAYLOAD_W      = CHANNEL_COUNT * CHAN_W;

    typedef enum {
        FRAME_CLEAN,
        FRAME_BAD_SYNC,
        FRAME_BAD_LENGTH,
        FRAME_BAD_TYPE,
        FRAME_BAD_CRC,
        FRAME_CUT
    } t_frame_flaw;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_wdata = '0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [BYTE_W-1:0]         rx_byte = '0;
    logic                      frame_start = 1'b0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [CH_IDX_W-1:0]       channel_index;
    logic signed [VALUE_W-1:0] scaled_value;
    logic [1:0]                frame_status;
    logic                      last_of_frame;
    int                        fail_count;
    int                        words_due;

    int   in_idle_pct = 11;
    int   out_idle_pct = 83;
    int   items_sent = 0;
    int   quiet_cycles = 0;
    t_cfg cur = CFG_RESET;

    crsf_rc_channel_frame_decoder dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_rx_byte       (rx_byte),
        .i_frame_start   (frame_start),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_channel_index (channel_index),
        .o_scaled_value  (scaled_value),
        .o_frame_status  (frame_status),
        .o_last_of_frame (last_of_frame)
    );

    crsf_rc_channel_frame_decoder_checker chk (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_rx_byte       (rx_byte),
        .i_frame_start   (frame_start),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_channel_index (channel_index),
        .i_scaled_value  (scaled_value),
        .i_frame_status  (frame_status),
        .i_last_of_frame (last_of_frame),
        .o_fail_count    (fail_count),
        .o_words_due     (words_due)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // Randomly stall the output side
    initial begin
        forever begin
            @(negedge clk);
            out_stall <= ($urandom_range(0, 99) < out_idle_pct);
        end
    end

    // End the run if nothing moves for too long
    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("crsf_rc_channel_frame_decoder: mismatch");
        $finish;
    end

    function automatic logic [BYTE_W-1:0] crc_step(
        input logic [BYTE_W-1:0] crc_in,
        input logic [BYTE_W-1:0] data
    );
        logic [BYTE_W-1:0] r;
        r = crc_in ^ data;
        for (int k = 0; k < BYTE_W; k++) begin
            if (r[BYTE_W-1]) begin
                r = (r << 1) ^ CRC_POLY;
            end else begin
                r = r << 1;
            end
        end
        return r;
    endfunction

    function automatic logic [PAYLOAD_W-1:0] random_channels();
        logic [PAYLOAD_W-1:0] p;
        for (int i = 0; i < CHANNEL_COUNT; i++) begin
            case ($urandom_range(0, 5))
                0:       p[i*CHAN_W +: CHAN_W] = '0;
                1:       p[i*CHAN_W +: CHAN_W] = '1;
                default: p[i*CHAN_W +: CHAN_W] = CHAN_W'($urandom_range(0, 2047));
            endcase
        end
        return p;
    endfunction

    // Offer one byte, with an optional gap first; hold it until taken
    task automatic put_byte(input logic [BYTE_W-1:0] b, input logic start, input logic counted);
        if ($urandom_range(0, 99) < in_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        frame_start <= start;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        if (counted) items_sent++;
    endtask

    // Send one frame, optionally broken at one point
    task automatic send_frame(input logic [PAYLOAD_W-1:0] chans, input t_frame_flaw flaw);
        logic [BYTE_W-1:0] crc;
        logic [BYTE_W-1:0] b;
        int cut_at;
        cut_at = $urandom_range(0, 20);
        if (flaw == FRAME_BAD_SYNC) begin
            put_byte(cur.sync_value ^ BYTE_W'($urandom_range(1, 255)), 1'b1, 1'b1);
            return;
        end
        put_byte(cur.sync_value, 1'b1, 1'b1);
        if (flaw == FRAME_BAD_LENGTH) begin
            put_byte(FRAME_LENGTH ^ BYTE_W'($urandom_range(1, 255)), 1'b0, 1'b1);
            return;
        end
        put_byte(FRAME_LENGTH, 1'b0, 1'b1);
        if (flaw == FRAME_BAD_TYPE) begin
            put_byte(cur.frame_type ^ BYTE_W'($urandom_range(1, 255)), 1'b0, 1'b1);
            return;
        end
        put_byte(cur.frame_type, 1'b0, 1'b1);
        crc = crc_step('0, cur.frame_type);
        for (int k = 0; k < PAYLOAD_W / BYTE_W; k++) begin
            b = chans[k*BYTE_W +: BYTE_W];
            crc = crc_step(crc, b);
            put_byte(b, 1'b0, 1'b1);
            // drop the rest; the next frame start abandons this one
            if (flaw == FRAME_CUT && k == cut_at) return;
        end
        if (flaw == FRAME_BAD_CRC) crc = crc ^ BYTE_W'($urandom_range(1, 255));
        put_byte(crc, 1'b0, 1'b1);
    endtask

    // Stop offering, let every owed word arrive, then let the block settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        frame_start <= 1'b0;
        @(negedge clk);
        while (words_due != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Write all six registers on consecutive cycles
    task automatic load_settings(input t_cfg c);
        t_cfg_index idx;
        cur = c;
        for (int k = 0; k < REG_COUNT; k++) begin
            idx = t_cfg_index'(k);
            cfg_we <= 1'b1;
            cfg_index <= idx;
            case (idx)
                CFG_SYNC:       cfg_wdata <= CFG_DATA_W'(c.sync_value);
                CFG_FRAME_TYPE: cfg_wdata <= CFG_DATA_W'(c.frame_type);
                CFG_STICK_MIN:  cfg_wdata <= CFG_DATA_W'(c.stick_min);
                CFG_STICK_GAIN: cfg_wdata <= CFG_DATA_W'(c.stick_gain);
                CFG_AUX_MIN:    cfg_wdata <= CFG_DATA_W'(c.aux_min);
                CFG_AUX_GAIN:   cfg_wdata <= CFG_DATA_W'(c.aux_gain);
                default:        cfg_wdata <= '0;
            endcase
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Mostly clean frames with random content, some broken ones and line noise
    task automatic run_phase(input int in_pct, input int out_pct);
        int goal;
        int pick;
        in_idle_pct = in_pct;
        out_idle_pct = out_pct;
        goal = items_sent + PHASE_ITEMS;
        while (items_sent < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) send_frame(random_channels(), FRAME_CLEAN);
            else if (pick < 72) send_frame(random_channels(), FRAME_BAD_CRC);
            else if (pick < 77) send_frame(random_channels(), FRAME_BAD_SYNC);
            else if (pick < 82) send_frame(random_channels(), FRAME_BAD_LENGTH);
            else if (pick < 87) send_frame(random_channels(), FRAME_BAD_TYPE);
            else if (pick < 93) send_frame(random_channels(), FRAME_CUT);
            else begin
                repeat ($urandom_range(1, 4)) begin
                    put_byte(BYTE_W'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0), 1'b0);
                end
            end
        end
        wait_idle();
    endtask

    initial begin
        logic [CHAN_W-1:0]    corner_vals [CHANNEL_COUNT];
        logic [PAYLOAD_W-1:0] corner_frame;
        t_cfg                 mix;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed frames at the reset settings
        corner_vals = '{11'd0, 11'd2047, 11'd172, 11'd171, 11'd173, 11'd1024, 11'd1, 11'd2046,
                        11'h555, 11'h2AA, 11'd992, 11'd1811, 11'd0, 11'd2047, 11'd172, 11'd1500};
        for (int i = 0; i < CHANNEL_COUNT; i++) corner_frame[i*CHAN_W +: CHAN_W] = corner_vals[i];
        put_byte(8'h00, 1'b0, 1'b0);
        put_byte(8'hFF, 1'b0, 1'b0);
        send_frame(corner_frame, FRAME_CLEAN);
        put_byte(cur.sync_value, 1'b0, 1'b0);
        send_frame(random_channels(), FRAME_BAD_SYNC);
        send_frame(random_channels(), FRAME_BAD_LENGTH);
        send_frame(random_channels(), FRAME_BAD_TYPE);
        send_frame(random_channels(), FRAME_BAD_CRC);
        send_frame(random_channels(), FRAME_CUT);
        send_frame(~corner_frame, FRAME_CLEAN);
        wait_idle();

        // Extreme gains and offsets: saturate both ways
        load_settings('{sync_value: 8'd0, frame_type: 8'd255, stick_min: 11'd0,
                        stick_gain: 16'hFFFF, aux_min: 11'd2047, aux_gain: 16'hFFFF});
        send_frame(corner_frame, FRAME_CLEAN);
        run_phase(11, 83);

        load_settings('{sync_value: 8'd255, frame_type: 8'd0, stick_min: 11'd2047,
                        stick_gain: 16'd0, aux_min: 11'd0, aux_gain: 16'd1});
        run_phase(83, 11);

        mix.sync_value = BYTE_W'($urandom_range(0, 255));
        mix.frame_type = BYTE_W'($urandom_range(0, 255));
        mix.stick_min = CHAN_W'($urandom_range(0, 2047));
        mix.stick_gain = GAIN_W'($urandom_range(0, 65535));
        mix.aux_min = CHAN_W'($urandom_range(0, 2047));
        mix.aux_gain = GAIN_W'($urandom_range(0, 65535));
        load_settings(mix);
        run_phase(0, 0);

        if (fail_count == 0 && words_due == 0) begin
            $display("crsf_rc_channel_frame_decoder: match");
        end else begin
            $display("crsf_rc_channel_frame_decoder: mismatch");
        end
        $finish;
    end

endmodule
